// ----- rtl/bmf_pkg.sv -----
// Package: shared constants, types and codes for the bitmap line and fill core.
`default_nettype none
package bmf_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned QUEUE_DEPTH = 65536;

  localparam int unsigned CW   = 8;
  localparam int unsigned GW   = 9;
  localparam int unsigned CAW  = 2 * CW;
  localparam int unsigned QAW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW  = QAW + 1;
  localparam int unsigned ERRW = 11;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_LINE  = 2'd1,
    OP_FILL  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic [1:0] CELL_EMPTY  = 2'd0;
  localparam logic [1:0] CELL_WALL   = 2'd1;
  localparam logic [1:0] CELL_FILLED = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CW-1:0]          x;
    logic [CW-1:0]          y;
    logic signed [ERRW-1:0] err;
    logic                   last;
  } line_step_t;

endpackage
`default_nettype wire

// ----- rtl/bmf_if.sv -----
// Interfaces: command and result channels with valid/ready handshake.
`default_nettype none
interface bmf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] start_x;
  logic [7:0] start_y;
  logic [7:0] end_x;
  logic [7:0] end_y;
  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bmf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_value;
  modport source (output valid, cell_value, input ready);
  modport sink (input valid, cell_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/bmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmf_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/bmf_line_unit.sv -----
// Bresenham step unit: next point and error term of a line walk.
`default_nettype none
module bmf_line_unit (
  input  wire logic [bmf_pkg::CW-1:0]          x_i,
  input  wire logic [bmf_pkg::CW-1:0]          y_i,
  input  wire logic [bmf_pkg::CW-1:0]          tx_i,
  input  wire logic [bmf_pkg::CW-1:0]          ty_i,
  input  wire logic [bmf_pkg::CW-1:0]          dx_i,
  input  wire logic [bmf_pkg::CW-1:0]          dy_i,
  input  wire logic                            sx_neg_i,
  input  wire logic                            sy_neg_i,
  input  wire logic signed [bmf_pkg::ERRW-1:0] err_i,
  output bmf_pkg::line_step_t                  step_o
);
  import bmf_pkg::*;

  logic signed [ERRW:0]   e2;
  logic signed [ERRW:0]   dxs;
  logic signed [ERRW:0]   dys;
  logic signed [ERRW-1:0] err_a;

  always_comb begin
    e2    = {err_i, 1'b0};
    dxs   = $signed({{(ERRW+1-CW){1'b0}}, dx_i});
    dys   = $signed({{(ERRW+1-CW){1'b0}}, dy_i});
    err_a = err_i;
    step_o.x    = x_i;
    step_o.y    = y_i;
    step_o.last = (x_i == tx_i) && (y_i == ty_i);
    if (e2 > -dys) begin
      err_a    = err_a - dys[ERRW-1:0];
      step_o.x = sx_neg_i ? x_i - 1'b1 : x_i + 1'b1;
    end
    if (e2 < dxs) begin
      err_a    = err_a + dxs[ERRW-1:0];
      step_o.y = sy_neg_i ? y_i - 1'b1 : y_i + 1'b1;
    end
    step_o.err = err_a;
  end
endmodule
`default_nettype wire

// ----- rtl/bitmap_line_and_flood_fill_core.sv -----
// Top level: command sequencer, cell store, fill queue and line step unit.
// Read: the cell store read is registered and taken in S_READ_WT; line: one visited
// cell per cycle. Fill: a neighbor probe reads the cell store in S_NB and checks it in
// S_CHK; a dequeued cell is read from the queue in S_POP. Clear: one cell a cycle.
// One command at a time; the next is accepted while a result waits.
// After reset a clearing pass over all 65536 cells runs before the first command.
`default_nettype none
module bitmap_line_and_flood_fill_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [bmf_pkg::GW-1:0] cfg_data_i,
  bmf_in_if.sink                    in_item,
  bmf_out_if.source                 out_item
);
  import bmf_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_READ_WT = 4'd2;
  localparam logic [3:0] S_LINE    = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_NB      = 4'd5;
  localparam logic [3:0] S_POP     = 4'd6;
  localparam logic [3:0] S_POP_WT  = 4'd7;
  localparam logic [3:0] S_CLEAR   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]             state_q, state_d;
  logic [GW-1:0]          gw_q, gh_q, w_eff, h_eff;
  logic [CW-1:0]          lx_q, lx_d, ly_q, ly_d, tx_q, tx_d, ty_q, ty_d;
  logic [CW-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic                   sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ERRW-1:0] err_q, err_d;
  logic [CAW-1:0]         cand_q, cand_d, clr_q, clr_d;
  logic [CW-1:0]          px_q, px_d, py_q, py_d;
  logic [1:0]             nb_q, nb_d;
  logic                   seed_q, seed_d;
  logic [QCW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [1:0]             res_q, res_d;
  logic                   ov_q, ov_d;
  logic [1:0]             oval_q, oval_d;

  logic                   cell_we;
  logic [CAW-1:0]         cell_waddr, cell_raddr;
  logic [1:0]             cell_wdata, cell_rdata;
  logic                   q_we;
  logic [QAW-1:0]         q_raddr;
  logic [CAW-1:0]         q_rdata;
  line_step_t             step;
  logic                   in_acc, in_grid_in, in_grid_ln;
  logic                   nb_ok;
  logic [CW-1:0]          nx, ny;

  bmf_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  bmf_ram #(.WIDTH(CAW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q[QAW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  bmf_line_unit u_line (
    .x_i      (lx_q),
    .y_i      (ly_q),
    .tx_i     (tx_q),
    .ty_i     (ty_q),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .sx_neg_i (sxn_q),
    .sy_neg_i (syn_q),
    .err_i    (err_q),
    .step_o   (step)
  );

  assign w_eff = (gw_q > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : gw_q;
  assign h_eff = (gh_q > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : gh_q;

  assign in_item.ready       = (state_q == S_IDLE);
  assign in_acc              = in_item.valid && in_item.ready;
  assign in_grid_in          = ({1'b0, in_item.start_x} < w_eff) &&
                               ({1'b0, in_item.start_y} < h_eff);
  assign in_grid_ln          = ({1'b0, lx_q} < w_eff) && ({1'b0, ly_q} < h_eff);
  assign out_item.valid      = ov_q;
  assign out_item.cell_value = oval_q;

  always_comb begin
    nx    = px_q;
    ny    = py_q;
    nb_ok = 1'b0;
    case (nb_q)
      2'd0: begin
        nx    = px_q + 1'b1;
        nb_ok = ({1'b0, px_q} + 1'b1) < w_eff;
      end
      2'd1: begin
        nx    = px_q - 1'b1;
        nb_ok = (px_q != '0);
      end
      2'd2: begin
        ny    = py_q + 1'b1;
        nb_ok = ({1'b0, py_q} + 1'b1) < h_eff;
      end
      default: begin
        ny    = py_q - 1'b1;
        nb_ok = (py_q != '0);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    lx_d = lx_q; ly_d = ly_q; tx_d = tx_q; ty_d = ty_q;
    dx_d = dx_q; dy_d = dy_q; sxn_d = sxn_q; syn_d = syn_q; err_d = err_q;
    cand_d = cand_q; clr_d = clr_q; px_d = px_q; py_d = py_q;
    nb_d = nb_q; seed_d = seed_q; head_d = head_q; tail_d = tail_q;
    res_d = res_q; ov_d = ov_q; oval_d = oval_q;
    cell_we    = 1'b0;
    cell_waddr = cand_q;
    cell_wdata = CELL_FILLED;
    cell_raddr = cand_q;
    q_we       = 1'b0;
    q_raddr    = head_q[QAW-1:0];

    if (ov_q && out_item.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        cell_wdata = CELL_EMPTY;
        clr_d      = clr_q + 1'b1;
        if (clr_q == '1) begin
          res_d   = CELL_EMPTY;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        cell_raddr = {in_item.start_y, in_item.start_x};
        if (in_acc) begin
          res_d = CELL_EMPTY;
          unique case (op_e'(in_item.op))
            OP_READ: begin
              if (in_grid_in) begin
                state_d = S_READ_WT;
              end else begin
                res_d   = CELL_WALL;
                state_d = S_DONE;
              end
            end
            OP_LINE: begin
              lx_d  = in_item.start_x;
              ly_d  = in_item.start_y;
              tx_d  = in_item.end_x;
              ty_d  = in_item.end_y;
              sxn_d = !(in_item.start_x < in_item.end_x);
              syn_d = !(in_item.start_y < in_item.end_y);
              dx_d  = (in_item.end_x > in_item.start_x) ?
                      in_item.end_x - in_item.start_x : in_item.start_x - in_item.end_x;
              dy_d  = (in_item.end_y > in_item.start_y) ?
                      in_item.end_y - in_item.start_y : in_item.start_y - in_item.end_y;
              err_d = $signed({{(ERRW-CW){1'b0}}, dx_d}) -
                      $signed({{(ERRW-CW){1'b0}}, dy_d});
              state_d = S_LINE;
            end
            OP_FILL: begin
              head_d = '0;
              tail_d = '0;
              if (in_grid_in) begin
                cand_d  = {in_item.start_y, in_item.start_x};
                seed_d  = 1'b1;
                state_d = S_CHK;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
          endcase
        end
      end
      S_READ_WT: begin
        res_d   = cell_rdata;
        state_d = S_DONE;
      end
      S_LINE: begin
        cell_we    = in_grid_ln;
        cell_waddr = {ly_q, lx_q};
        cell_wdata = CELL_WALL;
        if (step.last) begin
          state_d = S_DONE;
        end else begin
          lx_d  = step.x;
          ly_d  = step.y;
          err_d = step.err;
        end
      end
      S_CHK: begin
        if ((cell_rdata == CELL_EMPTY) && ((tail_q - head_q) < QCW'(QUEUE_DEPTH))) begin
          cell_we = 1'b1;
          q_we    = 1'b1;
          tail_d  = tail_q + 1'b1;
        end
        if (seed_q) begin
          seed_d  = 1'b0;
          state_d = S_POP;
        end else if (nb_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          nb_d    = nb_q + 1'b1;
          state_d = S_NB;
        end
      end
      S_NB: begin
        cell_raddr = {ny, nx};
        if (nb_ok) begin
          cand_d  = {ny, nx};
          state_d = S_CHK;
        end else if (nb_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          nb_d = nb_q + 1'b1;
        end
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_DONE;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = S_POP_WT;
        end
      end
      S_POP_WT: begin
        px_d    = q_rdata[CW-1:0];
        py_d    = q_rdata[CAW-1:CW];
        nb_d    = '0;
        state_d = S_NB;
      end
      S_DONE: begin
        if (!ov_q || out_item.ready) begin
          ov_d    = 1'b1;
          oval_d  = res_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      seed_q  <= 1'b0;
      nb_q    <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      gw_q    <= GW'(256);
      gh_q    <= GW'(256);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      seed_q  <= seed_d;
      nb_q    <= nb_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg_we_i && (cfg_idx_i == REG_WIDTH)) begin
        gw_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_HEIGHT)) begin
        gh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q <= lx_d; ly_q <= ly_d; tx_q <= tx_d; ty_q <= ty_d;
    dx_q <= dx_d; dy_q <= dy_d; sxn_q <= sxn_d; syn_q <= syn_d; err_q <= err_d;
    cand_q <= cand_d; px_q <= px_d; py_q <= py_d;
    res_q <= res_d; oval_q <= oval_d;
  end

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");

  a_fill_writes_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_we && state_q == S_CHK) |-> (cell_wdata == CELL_FILLED))
    else $error("fill wrote a value other than filled");

  a_line_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_we && state_q == S_LINE) |-> in_grid_ln)
    else $error("line wrote outside the grid");

  a_done_to_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !ov_q) |=> ov_q)
    else $error("finished command did not present its result");

endmodule
`default_nettype wire
